FILE: hdl/sspi_pkg.sv
// Shared constants, types and register codes of the schedule setpoint interpolator.
package sspi_pkg;

  // Schedule geometry
  localparam int MAX_ENTRIES = 8;
  localparam int SEASONS     = 4;
  localparam int BANK_DEPTH  = SEASONS * MAX_ENTRIES;
  localparam int ADDR_W      = $clog2(BANK_DEPTH);
  localparam int ENT_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Field widths
  localparam int SEASON_W   = 2;
  localparam int INDEX_W    = 3;
  localparam int MINUTE_W   = 11;
  localparam int TEMP_W     = 10;
  localparam int QMIN_W     = 16;
  localparam int COUNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int MINUTES_PER_DAY = 24 * 60;
  localparam int PERCENT         = 100;
  localparam int TEMP_MAX        = (2 ** TEMP_W) - 1;

  // Minute reduction: one conditional subtract of MINUTES_PER_DAY << step per cycle
  localparam int MOD_STEPS = $clog2(((2 ** QMIN_W) - 1) / MINUTES_PER_DAY + 1);
  localparam int STEP_W    = $clog2(MOD_STEPS);

  // Interpolation arithmetic
  localparam int OFS_W   = MINUTE_W + 2;       // signed offset and span in minutes
  localparam int DVS_W   = OFS_W - 1;          // divisor magnitude
  localparam int NUM_W   = 19;                 // magnitude of offset * PERCENT
  localparam int DIFF_W  = TEMP_W + 1;         // signed setpoint difference
  localparam int PROD_W  = DIFF_W + NUM_W + 1; // signed difference * fraction
  localparam int DIVD_W  = 29;                 // magnitude of that product
  localparam int SUM_W   = DIVD_W + 2;
  localparam int ITER_W  = $clog2(DIVD_W + 1);

  // Scaling by PERCENT: multiply by a rounded-up reciprocal, then shift.
  // The rounding error times any DIVD_W-bit magnitude stays below 2**RECIP_SHIFT.
  localparam int     RECIP_SHIFT = 35;
  localparam int     RECIP_W     = 29;
  localparam longint RECIP_PCT   = ((longint'(1) << RECIP_SHIFT) + PERCENT - 1) / PERCENT;
  localparam int     SCALED_W    = DIVD_W + RECIP_W;

  typedef struct packed {
    logic [MINUTE_W-1:0] start;
    logic [TEMP_W-1:0]   temp;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef struct packed {
    logic              go;
    logic [DIVD_W-1:0] dividend;
    logic [DVS_W-1:0]  divisor;
    logic [ITER_W-1:0] iters;
  } div_cmd_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quo;
  } div_stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_SEASON = 3'd0,
    CFG_COUNT_SPRING  = 3'd1,
    CFG_COUNT_SUMMER  = 3'd2,
    CFG_COUNT_AUTUMN  = 3'd3,
    CFG_COUNT_WINTER  = 3'd4,
    CFG_AVG_MODE      = 3'd5,
    CFG_VACATION_MODE = 3'd6,
    CFG_VACATION_TEMP = 3'd7
  } cfg_reg_t;

endpackage

FILE: hdl/sspi_if.sv
// Channel interfaces: request words, response words and configuration writes.
interface sspi_req_if;
  import sspi_pkg::*;
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [SEASON_W-1:0] entry_season;
  logic [INDEX_W-1:0]  entry_index;
  logic [MINUTE_W-1:0] entry_minute;
  logic [TEMP_W-1:0]   entry_temp;
  logic [QMIN_W-1:0]   query_minute;

  modport source (output valid, req_type, entry_season, entry_index, entry_minute,
                  entry_temp, query_minute, input ready);
  modport sink (input valid, req_type, entry_season, entry_index, entry_minute,
                entry_temp, query_minute, output ready);
endinterface

interface sspi_rsp_if;
  import sspi_pkg::*;
  logic               valid;
  logic               ready;
  logic [TEMP_W-1:0]  target_temp;
  logic [INDEX_W-1:0] matched_entry;

  modport source (output valid, target_temp, matched_entry, input ready);
  modport sink (input valid, target_temp, matched_entry, output ready);
endinterface

interface sspi_cfg_if;
  import sspi_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

FILE: hdl/sspi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sspi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/sspi_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, dividend left-aligned.
module sspi_div (
  input  logic                clk,
  input  logic                rst,
  input  sspi_pkg::div_cmd_t  cmd,
  output sspi_pkg::div_stat_t stat
);
  import sspi_pkg::*;

  logic              busy;
  logic              done;
  logic [ITER_W-1:0] cnt;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [DIVD_W-1:0] shreg;

  logic [DVS_W:0]    trial;
  logic              ge;
  logic [DVS_W-1:0]  rem_next;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial    = {rem, shreg[DIVD_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign rem_next = ge ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.go) begin
        busy <= 1'b1;
        cnt  <= cmd.iters;
      end else if (busy) begin
        cnt <= cnt - ITER_W'(1);
        if (cnt == ITER_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Load operands, then shift quotient bits in
  always_ff @(posedge clk) begin
    if (cmd.go) begin
      rem   <= '0;
      dvs   <= cmd.divisor;
      shreg <= cmd.dividend;
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= {shreg[DIVD_W-2:0], ge};
    end
  end

  assign stat.done = done;
  assign stat.quo  = shreg;

endmodule

FILE: hdl/schedule_setpoint_interpolator.sv
// Top level: schedule memory, lookup sequencer and setpoint interpolation.
//
// Stores a daily setpoint schedule of up to MAX_ENTRIES entries for each of
// SEASONS seasons in one synchronous RAM, and answers one word per request.
// A write request stores an entry and answers zero. A query reduces its
// minute modulo 1440, then reads the active season's entries one per cycle
// (one RAM read port). In averaging mode a one-bit-per-cycle divider forms
// the fraction as 19 quotient bits and a reciprocal multiply divides by 100.
// The block takes one request at a time; a finished word waits in the
// output register while the next request is taken. The schedule RAM is not
// cleared after reset: entries must be written before a query reaches them.
// Configuration writes are taken in every cycle and must only be issued while
// the block is idle.
module schedule_setpoint_interpolator (
  input logic        clk,
  input logic        rst,
  sspi_req_if.sink   req,
  sspi_rsp_if.source rsp,
  sspi_cfg_if.sink   cfg
);
  import sspi_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_MOD   = 10'b0000000010,
    ST_WALK  = 10'b0000000100,
    ST_PREP  = 10'b0000001000,
    ST_DIV1  = 10'b0000010000,
    ST_MUL   = 10'b0000100000,
    ST_SCALE = 10'b0001000000,
    ST_QUO   = 10'b0010000000,
    ST_SUM   = 10'b0100000000,
    ST_EMIT  = 10'b1000000000
  } state_t;

  // Configuration registers
  logic [SEASON_W-1:0] active_season;
  logic [COUNT_W-1:0]  counts [4];
  logic                avg_mode;
  logic                vacation_mode;
  logic [TEMP_W-1:0]   vacation_temp;

  // Sequencer state
  state_t              state;
  logic [QMIN_W-1:0]   minute;
  logic [STEP_W-1:0]   step;
  logic [CNT_W-1:0]    k;
  logic                found;
  logic [ENT_W-1:0]    idx;
  logic [ENT_W-1:0]    last;
  logic [ADDR_W-1:0]   base;
  entry_t              first;
  entry_t              prev;
  entry_t              ent;
  entry_t              nxt;
  logic                q_neg;
  logic [DIFF_W-1:0]   diff;
  logic [NUM_W:0]      q1;
  logic [PROD_W-1:0]   prod;
  logic [SCALED_W-1:0] scaled;
  logic [SUM_W-1:0]    q2;
  logic [TEMP_W-1:0]   res_temp;
  logic [INDEX_W-1:0]  res_idx;
  logic                out_valid;
  logic [TEMP_W-1:0]   out_temp;
  logic [INDEX_W-1:0]  out_idx;
  logic                div_go;
  logic [DIVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]    div_dvs;
  div_cmd_t            div_cmd;

  // Combinational helpers
  logic [SEASON_W-1:0] season_eff;
  logic [COUNT_W-1:0]  cnt_used;
  logic                req_take;
  logic                emit;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [ENTRY_BITS-1:0] ram_rdata;
  entry_t              cur;
  entry_t              wr_entry;
  logic [CNT_W-1:0]    t;
  logic [MINUTE_W-1:0] min11;
  logic [QMIN_W:0]     mod_sub;
  logic                wrap;
  logic [OFS_W-1:0]    m_ofs;
  logic [OFS_W-1:0]    rng;
  logic [OFS_W-1:0]    rng_fix;
  logic [OFS_W-1:0]    rng_abs;
  logic [NUM_W:0]      num;
  logic [NUM_W:0]      num_abs;
  logic [PROD_W-1:0]   prod_abs;
  logic [SCALED_W-RECIP_SHIFT-1:0] quo_pct;
  logic [SUM_W-1:0]    sum;
  logic [TEMP_W-1:0]   sum_sat;
  div_stat_t           div_stat;

  function automatic logic [SEASON_W-1:0] season_mod(input logic [SEASON_W-1:0] s_in);
    logic [SEASON_W-1:0] s;
    s = s_in;
    for (int i = 0; i < 3; i++) begin
      if (int'(s) >= SEASONS) begin
        s = s - SEASON_W'(SEASONS);
      end
    end
    return s;
  endfunction

  // Active season and its clamped entry count
  always_comb begin
    season_eff = season_mod(active_season);
    cnt_used   = counts[season_eff];
    if (cnt_used == '0) begin
      cnt_used = COUNT_W'(1);
    end
    if (int'(cnt_used) > MAX_ENTRIES) begin
      cnt_used = COUNT_W'(MAX_ENTRIES);
    end
  end

  // Configuration port
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_season <= '0;
      for (int i = 0; i < 4; i++) begin
        counts[i] <= COUNT_W'(1);
      end
      avg_mode      <= 1'b0;
      vacation_mode <= 1'b0;
      vacation_temp <= TEMP_W'(600);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ACTIVE_SEASON: active_season <= cfg.wdata[SEASON_W-1:0];
        CFG_COUNT_SPRING:  counts[0]     <= cfg.wdata[COUNT_W-1:0];
        CFG_COUNT_SUMMER:  counts[1]     <= cfg.wdata[COUNT_W-1:0];
        CFG_COUNT_AUTUMN:  counts[2]     <= cfg.wdata[COUNT_W-1:0];
        CFG_COUNT_WINTER:  counts[3]     <= cfg.wdata[COUNT_W-1:0];
        CFG_AVG_MODE:      avg_mode      <= cfg.wdata[0];
        CFG_VACATION_MODE: vacation_mode <= cfg.wdata[0];
        CFG_VACATION_TEMP: vacation_temp <= cfg.wdata[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Schedule memory: entries written from idle, read one per cycle in the walk
  assign req.ready = (state == ST_IDLE);
  assign req_take  = req.valid && req.ready;
  assign ram_we    = req_take && !req.req_type && (int'(req.entry_season) < SEASONS) &&
                     (int'(req.entry_index) < MAX_ENTRIES);
  assign ram_waddr = ADDR_W'(int'(req.entry_season) * MAX_ENTRIES + int'(req.entry_index));
  assign wr_entry  = '{start: req.entry_minute, temp: req.entry_temp};
  assign ram_raddr = base + ADDR_W'(k[ENT_W-1:0]);
  assign cur       = entry_t'(ram_rdata);

  // Output word is loaded when the slot is free or being emptied
  assign emit = (state == ST_EMIT) && (!out_valid || rsp.ready);

  sspi_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(BANK_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_entry),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign div_cmd = '{go: div_go, dividend: div_dvd, divisor: div_dvs,
                     iters: ITER_W'(NUM_W)};

  sspi_div u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .stat(div_stat)
  );

  // Datapath terms
  always_comb begin
    t       = k - CNT_W'(1);
    min11   = minute[MINUTE_W-1:0];
    mod_sub = (QMIN_W + 1)'(MINUTES_PER_DAY) << step;
    wrap    = (idx == last);
    if (min11 < ent.start) begin
      m_ofs = OFS_W'(min11) + OFS_W'(MINUTES_PER_DAY) - OFS_W'(ent.start);
    end else begin
      m_ofs = OFS_W'(min11) - OFS_W'(ent.start);
    end
    rng = OFS_W'(nxt.start) - OFS_W'(ent.start) +
          (wrap ? OFS_W'(MINUTES_PER_DAY) : {OFS_W{1'b0}});
    rng_fix  = (rng == '0) ? OFS_W'(1) : rng;
    rng_abs  = rng_fix[OFS_W-1] ? (~rng_fix + OFS_W'(1)) : rng_fix;
    num      = {{(NUM_W + 1 - OFS_W){m_ofs[OFS_W-1]}}, m_ofs} * (NUM_W + 1)'(PERCENT);
    num_abs  = num[NUM_W] ? (~num + (NUM_W + 1)'(1)) : num;
    prod_abs = prod[PROD_W-1] ? (~prod + PROD_W'(1)) : prod;
    quo_pct  = scaled[SCALED_W-1:RECIP_SHIFT];
    sum      = SUM_W'(ent.temp) + q2;
    if (sum[SUM_W-1]) begin
      sum_sat = '0;
    end else if (sum > SUM_W'(TEMP_MAX)) begin
      sum_sat = TEMP_W'(TEMP_MAX);
    end else begin
      sum_sat = sum[TEMP_W-1:0];
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      div_go    <= 1'b0;
      found     <= 1'b0;
    end else begin
      div_go <= 1'b0;
      // Load a finished word, or drop the one taken
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_take) begin
            state <= req.req_type ? ST_MOD : ST_EMIT;
          end
        end
        ST_MOD: begin
          if (step == '0) begin
            state <= ST_WALK;
            found <= 1'b0;
          end
        end
        ST_WALK: begin
          if (k != '0 && !found) begin
            if (t != '0 && min11 >= prev.start && min11 < cur.start) begin
              found <= 1'b1;
            end else if (t == CNT_W'(last)) begin
              found <= 1'b1;
            end
          end
          if (k == CNT_W'(last) + CNT_W'(1)) begin
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (vacation_mode || !avg_mode) begin
            state <= ST_EMIT;
          end else begin
            div_go <= 1'b1;
            state  <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_stat.done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL:   state <= ST_SCALE;
        ST_SCALE: state <= ST_QUO;
        ST_QUO:   state <= ST_SUM;
        ST_SUM:   state <= ST_EMIT;
        ST_EMIT: begin
          if (emit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        res_temp <= '0;
        res_idx  <= '0;
        minute   <= req.query_minute;
        step     <= STEP_W'(MOD_STEPS - 1);
        base     <= ADDR_W'(int'(season_eff) * MAX_ENTRIES);
        last     <= ENT_W'(cnt_used - COUNT_W'(1));
        k        <= '0;
      end
      ST_MOD: begin
        // Strip MINUTES_PER_DAY << step from the minute when it fits
        if ({1'b0, minute} >= mod_sub) begin
          minute <= minute - mod_sub[QMIN_W-1:0];
        end
        step <= step - STEP_W'(1);
      end
      ST_WALK: begin
        k <= k + CNT_W'(1);
        if (k != '0) begin
          prev <= cur;
          if (t == '0) begin
            first <= cur;
          end
          if (!found) begin
            if (t != '0 && min11 >= prev.start && min11 < cur.start) begin
              idx <= t[ENT_W-1:0] - ENT_W'(1);
              ent <= prev;
              nxt <= cur;
            end else if (t == CNT_W'(last)) begin
              idx <= last;
              ent <= cur;
              nxt <= (t == '0) ? cur : first;
            end
          end
        end
      end
      ST_PREP: begin
        res_idx  <= INDEX_W'(idx);
        res_temp <= vacation_mode ? vacation_temp : ent.temp;
        diff     <= DIFF_W'(nxt.temp) - DIFF_W'(ent.temp);
        q_neg    <= num[NUM_W] ^ rng_fix[OFS_W-1];
        div_dvd  <= {num_abs[NUM_W-1:0], {(DIVD_W - NUM_W){1'b0}}};
        div_dvs  <= rng_abs[DVS_W-1:0];
      end
      ST_DIV1: begin
        if (q_neg) begin
          q1 <= ~{1'b0, div_stat.quo[NUM_W-1:0]} + (NUM_W + 1)'(1);
        end else begin
          q1 <= {1'b0, div_stat.quo[NUM_W-1:0]};
        end
      end
      ST_MUL: begin
        prod <= {{(PROD_W - DIFF_W){diff[DIFF_W-1]}}, diff} *
                {{(PROD_W - NUM_W - 1){q1[NUM_W]}}, q1};
      end
      ST_SCALE: begin
        // Divide the magnitude by PERCENT through the reciprocal
        q_neg  <= prod[PROD_W-1];
        scaled <= SCALED_W'(prod_abs[DIVD_W-1:0]) * SCALED_W'(RECIP_PCT);
      end
      ST_QUO: begin
        if (q_neg) begin
          q2 <= ~SUM_W'(quo_pct) + SUM_W'(1);
        end else begin
          q2 <= SUM_W'(quo_pct);
        end
      end
      ST_SUM: res_temp <= sum_sat;
      ST_EMIT: begin
        if (emit) begin
          out_temp <= res_temp;
          out_idx  <= res_idx;
        end
      end
      default: ;
    endcase
  end

  // Response word
  assign rsp.valid         = out_valid;
  assign rsp.target_temp   = out_temp;
  assign rsp.matched_entry = out_idx;

endmodule
